FILE: hdl/char_lcd_write_sequencer_core_assert.svh
// ---------------------------------------------------------------------------
// char_lcd_write_sequencer_core_assert.svh
// assertion macros shared by the lcd write sequencer
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CLCD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CLCD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define CLCD_ASSERT_IMP(label, clk, rst, ante, cons)
`define CLCD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/clcd_pkg.sv
// ---------------------------------------------------------------------------
// clcd_pkg
// types, codes and constants of the character lcd write sequencer
// ---------------------------------------------------------------------------
package clcd_pkg;

   // default row length in characters
   localparam int ROW_COLUMNS_DEFAULT = 16;

   // depth of the job and event queues
   localparam int JOB_DEPTH = 2;
   localparam int EVT_DEPTH = 2;

   // request kinds
   localparam logic [2:0] KIND_COMMAND  = 3'd0;
   localparam logic [2:0] KIND_CHAR     = 3'd1;
   localparam logic [2:0] KIND_POSITION = 3'd2;
   localparam logic [2:0] KIND_CLEAR    = 3'd3;
   localparam logic [2:0] KIND_INIT     = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_ENABLE_PULSE    = 3'd0;
   localparam logic [2:0] CSR_COMMAND_SETTLE  = 3'd1;
   localparam logic [2:0] CSR_DATA_SETTLE     = 3'd2;
   localparam logic [2:0] CSR_POWER_ON_WAIT   = 3'd3;
   localparam logic [2:0] CSR_FUNCTION_SET    = 3'd4;
   localparam logic [2:0] CSR_DISPLAY_CONTROL = 3'd5;
   localparam logic [2:0] CSR_ENTRY_MODE      = 3'd6;

   // register reset values
   localparam logic [15:0] ENABLE_PULSE_RESET    = 16'd1;
   localparam logic [15:0] COMMAND_SETTLE_RESET  = 16'd3000;
   localparam logic [15:0] DATA_SETTLE_RESET     = 16'd1000;
   localparam logic [15:0] POWER_ON_WAIT_RESET   = 16'd20000;
   localparam logic [7:0]  FUNCTION_SET_RESET    = 8'h38;
   localparam logic [7:0]  DISPLAY_CONTROL_RESET = 8'h0C;
   localparam logic [7:0]  ENTRY_MODE_RESET      = 8'h06;

   // fixed lcd instructions
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_HOME     = 8'h80;
   localparam logic [7:0] CMD_ROW1_POS = 8'h80;
   localparam logic [7:0] CMD_ROW2_POS = 8'hC0;

   // pin events per job
   localparam logic [3:0] WRITE_EVENTS = 4'd2;
   localparam logic [3:0] CLEAR_EVENTS = 4'd4;
   localparam logic [3:0] INIT_EVENTS  = 4'd11;

   typedef enum logic [1:0] {
      JOB_WRITE,
      JOB_CLEAR,
      JOB_INIT
   } job_kind_type;

   // classified request handed from front to back
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data_byte;
      logic         reg_select;
   } job_type;

   // one timed pin event
   typedef struct packed {
      logic [7:0]  data_bus;
      logic        reg_select;
      logic        enable;
      logic [15:0] hold_us;
      logic        last;
   } event_type;

   // configuration registers
   typedef struct packed {
      logic [15:0] enable_pulse_us;
      logic [15:0] command_settle_us;
      logic [15:0] data_settle_us;
      logic [15:0] power_on_wait_us;
      logic [7:0]  function_set_word;
      logic [7:0]  display_control_word;
      logic [7:0]  entry_mode_word;
   } cfg_type;

endpackage

FILE: hdl/clcd_fifo.sv
// ---------------------------------------------------------------------------
// clcd_fifo
// small register queue with push/full and pop/empty sides
// ---------------------------------------------------------------------------
module clcd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/clcd_front.sv
// ---------------------------------------------------------------------------
// clcd_front
// classifies requests into bus-write jobs, drops those that write nothing
// ---------------------------------------------------------------------------
module clcd_front #(
   parameter int ROW_COLUMNS = clcd_pkg::ROW_COLUMNS_DEFAULT
) (
   input  logic             [2:0] kind,
   input  logic             [7:0] data_byte,
   input  logic             [1:0] row,
   input  logic             [7:0] column,
   output logic                   job_valid,
   output clcd_pkg::job_type      job
);
   import clcd_pkg::*;

   logic col_ok;

   assign col_ok = (column < 8'(ROW_COLUMNS));

   // request decode
   always_comb begin
      job_valid      = 1'b0;
      job.kind       = JOB_WRITE;
      job.data_byte  = data_byte;
      job.reg_select = 1'b0;
      unique case (kind)
         KIND_COMMAND: begin
            job_valid = 1'b1;
         end
         KIND_CHAR: begin
            job_valid      = 1'b1;
            job.reg_select = 1'b1;
         end
         KIND_POSITION: begin
            job_valid = col_ok && ((row == 2'd1) || (row == 2'd2));
            job.data_byte = ((row == 2'd2) ? CMD_ROW2_POS : CMD_ROW1_POS) | column;
         end
         KIND_CLEAR: begin
            job_valid = 1'b1;
            job.kind  = JOB_CLEAR;
         end
         KIND_INIT: begin
            job_valid = 1'b1;
            job.kind  = JOB_INIT;
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
   end

endmodule

FILE: hdl/clcd_back.sv
// ---------------------------------------------------------------------------
// clcd_back
// steps through one job's pin events per run, one per cycle while evt_full is low
// ---------------------------------------------------------------------------
module clcd_back (
   input  logic                clock,
   input  logic                reset,
   input  clcd_pkg::cfg_type   cfg,
   input  logic                job_empty,
   input  clcd_pkg::job_type   job,
   output logic                job_pop,
   input  logic                evt_full,
   output logic                evt_push,
   output clcd_pkg::event_type evt
);
   import clcd_pkg::*;

   logic       busy_ff, busy_in;
   job_type    job_ff, job_in;
   logic [3:0] step_ff, step_in;
   logic [7:0] data_latch_ff, data_latch_in;
   logic       select_latch_ff, select_latch_in;

   logic [3:0] step_count;
   logic [3:0] rel_step;
   logic [2:0] write_idx;
   logic       phase_low;
   logic       is_wait;
   logic       is_last;
   logic [7:0] write_byte;
   logic       write_rs;
   logic       emit;
   logic       done;

   // position within the current job
   always_comb begin
      unique case (job_ff.kind)
         JOB_WRITE: step_count = WRITE_EVENTS;
         JOB_CLEAR: step_count = CLEAR_EVENTS;
         JOB_INIT:  step_count = INIT_EVENTS;
         default:   step_count = WRITE_EVENTS;
      endcase
   end

   assign is_wait   = (job_ff.kind == JOB_INIT) && (step_ff == '0);
   assign rel_step  = (job_ff.kind == JOB_INIT) ? step_ff - 1'b1 : step_ff;
   assign write_idx = rel_step[3:1];
   assign phase_low = rel_step[0];
   assign is_last   = (step_ff == step_count - 1'b1);

   // byte of the current bus write
   always_comb begin
      write_rs = (job_ff.kind == JOB_WRITE) ? job_ff.reg_select : 1'b0;
      unique case (job_ff.kind)
         JOB_WRITE: write_byte = job_ff.data_byte;
         JOB_CLEAR: write_byte = (write_idx == 3'd0) ? CMD_CLEAR : CMD_HOME;
         JOB_INIT: begin
            unique case (write_idx)
               3'd0:    write_byte = cfg.function_set_word;
               3'd1:    write_byte = cfg.display_control_word;
               3'd2:    write_byte = cfg.entry_mode_word;
               3'd3:    write_byte = CMD_CLEAR;
               default: write_byte = CMD_HOME;
            endcase
         end
         default: write_byte = job_ff.data_byte;
      endcase
   end

   // event assembly
   always_comb begin
      if (is_wait) begin
         evt.data_bus   = data_latch_ff;
         evt.reg_select = select_latch_ff;
         evt.enable     = 1'b0;
         evt.hold_us    = cfg.power_on_wait_us;
      end else begin
         evt.data_bus   = write_byte;
         evt.reg_select = write_rs;
         evt.enable     = !phase_low;
         if (!phase_low) begin
            evt.hold_us = cfg.enable_pulse_us;
         end else begin
            evt.hold_us = write_rs ? cfg.data_settle_us : cfg.command_settle_us;
         end
      end
      evt.last = is_last;
   end

   // handshake with the queues
   assign emit     = busy_ff && !evt_full;
   assign done     = emit && is_last;
   assign evt_push = emit;
   assign job_pop  = !job_empty && (!busy_ff || done);

   // sequencer next state
   always_comb begin
      busy_in         = busy_ff;
      job_in          = job_ff;
      step_in         = step_ff;
      data_latch_in   = data_latch_ff;
      select_latch_in = select_latch_ff;
      if (emit && !is_wait) begin
         data_latch_in   = write_byte;
         select_latch_in = write_rs;
      end
      if (job_pop) begin
         busy_in = 1'b1;
         job_in  = job;
         step_in = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         step_ff         <= '0;
         data_latch_ff   <= '0;
         select_latch_ff <= 1'b0;
      end else begin
         busy_ff         <= busy_in;
         step_ff         <= step_in;
         data_latch_ff   <= data_latch_in;
         select_latch_ff <= select_latch_in;
      end
   end

   // job payload
   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

FILE: hdl/char_lcd_write_sequencer_core.sv
// ---------------------------------------------------------------------------
// char_lcd_write_sequencer_core
// turns lcd requests into timed pin events for an 8-bit character lcd bus
// ---------------------------------------------------------------------------
// channel   direction  handshake         payload
// req       in         req_push/req_full kind, data_byte, row, column
// rsp       out        rsp_pop/rsp_empty data_bus, reg_select, read_write,
//                                        enable, hold_us, last
// csr       in         csr_write         csr_index, csr_wdata
//
// the back sequencer emits one pin event per cycle when the event queue has
// room; a command, character or set position makes 2 events, clear 4, init
// 11, and dropped requests make none. a request enters a 2-entry job queue
// in its accept cycle, events leave through a 2-entry event queue, so input
// and output stall independently. synchronous reset empties both queues,
// zeroes the pin latches and loads the register defaults.
// ---------------------------------------------------------------------------
`include "char_lcd_write_sequencer_core_assert.svh"

module char_lcd_write_sequencer_core #(
   parameter int ROW_COLUMNS = clcd_pkg::ROW_COLUMNS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [1:0]  req_row,
   input  logic [7:0]  req_column,
   // result side
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_data_bus,
   output logic        rsp_reg_select,
   output logic        rsp_read_write,
   output logic        rsp_enable,
   output logic [15:0] rsp_hold_us,
   output logic        rsp_last,
   // register writes
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import clcd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      front_valid;
   job_type   front_job;
   logic      job_empty;
   logic      job_pop;
   job_type   job_head;
   logic      evt_full;
   logic      evt_push;
   event_type evt_in;
   event_type evt_head;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ENABLE_PULSE:    cfg_in.enable_pulse_us      = csr_wdata;
            CSR_COMMAND_SETTLE:  cfg_in.command_settle_us    = csr_wdata;
            CSR_DATA_SETTLE:     cfg_in.data_settle_us       = csr_wdata;
            CSR_POWER_ON_WAIT:   cfg_in.power_on_wait_us     = csr_wdata;
            CSR_FUNCTION_SET:    cfg_in.function_set_word    = csr_wdata[7:0];
            CSR_DISPLAY_CONTROL: cfg_in.display_control_word = csr_wdata[7:0];
            CSR_ENTRY_MODE:      cfg_in.entry_mode_word      = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_pulse_us      <= ENABLE_PULSE_RESET;
         cfg_ff.command_settle_us    <= COMMAND_SETTLE_RESET;
         cfg_ff.data_settle_us       <= DATA_SETTLE_RESET;
         cfg_ff.power_on_wait_us     <= POWER_ON_WAIT_RESET;
         cfg_ff.function_set_word    <= FUNCTION_SET_RESET;
         cfg_ff.display_control_word <= DISPLAY_CONTROL_RESET;
         cfg_ff.entry_mode_word      <= ENTRY_MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request classification
   clcd_front #(
      .ROW_COLUMNS (ROW_COLUMNS)
   ) u_front (
      .kind      (req_kind),
      .data_byte (req_data_byte),
      .row       (req_row),
      .column    (req_column),
      .job_valid (front_valid),
      .job       (front_job)
   );

   // job queue between front and back
   clcd_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JOB_DEPTH)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && front_valid),
      .push_data (front_job),
      .full      (req_full),
      .pop       (job_pop),
      .pop_data  (job_head),
      .empty     (job_empty)
   );

   // event sequencer
   clcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .evt_full  (evt_full),
      .evt_push  (evt_push),
      .evt       (evt_in)
   );

   // event output queue
   clcd_fifo #(
      .WIDTH ($bits(event_type)),
      .DEPTH (EVT_DEPTH)
   ) u_evt_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data (evt_in),
      .full      (evt_full),
      .pop       (rsp_pop),
      .pop_data  (evt_head),
      .empty     (rsp_empty)
   );

   assign rsp_data_bus   = evt_head.data_bus;
   assign rsp_reg_select = evt_head.reg_select;
   assign rsp_read_write = 1'b0;
   assign rsp_enable     = evt_head.enable;
   assign rsp_hold_us    = evt_head.hold_us;
   assign rsp_last       = evt_head.last;

   // checks
   `CLCD_ASSERT_NXT(a_reset_empties, clock, 1'b0, reset, rsp_empty && !req_full)
   `CLCD_ASSERT_IMP(a_strobe_not_last, clock, reset, !rsp_empty && rsp_enable, !rsp_last)
   `CLCD_ASSERT_NXT(a_command_queued, clock, reset,
                    req_push && !req_full && (req_kind == KIND_COMMAND), !job_empty)

endmodule
